/* src/isrc_pkg.sv */
// Shared types and constants for the inductive sensor raw-code converter.
// Holds register indexes, register reset values and the inductance scale factor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isrc_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 17;

    localparam int OHM_BITS    = 17;
    localparam int CAP_BITS    = 16;
    localparam int PERIOD_BITS = 13;
    localparam int LK_BITS     = 30;
    localparam int IN_FIELD_BITS = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RP_MIN  = 3'd0,
        REG_RP_MAX  = 3'd1,
        REG_HIGH_Q  = 3'd2,
        REG_CAP     = 3'd3,
        REG_PERIODS = 3'd4
    } t_reg_idx;

    localparam logic [OHM_BITS-1:0]    RST_RP_MIN  = 17'd750;
    localparam logic [OHM_BITS-1:0]    RST_RP_MAX  = 17'd96000;
    localparam logic                   RST_HIGH_Q  = 1'b0;
    localparam logic [CAP_BITS-1:0]    RST_CAP     = 16'd100;
    localparam logic [PERIOD_BITS-1:0] RST_PERIODS = 13'd6144;

    // round(9e24 / (4 pi^2 (16 MHz)^2)): folds the reference clock and pH scaling.
    localparam logic [LK_BITS-1:0] LK = 30'd890518216;

endpackage

`default_nettype wire

/* src/inductive_sensor_raw_converter.sv */
// Top level of the inductive sensor raw-code converter: Rp and L from raw codes.
// Depends on isrc_pkg for register indexes, reset values and the L scale factor.
// One item is accepted per cycle while stage 0 can advance. The path has two multiply
// stages, one rounding and range check stage, then a restoring divider that resolves
// one quotient bit per stage for Rp and L side by side. Each stage moves on when it
// is empty or its successor moves, so a stalled output fills the bubbles first.
// Configuration writes are always taken and must only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module inductive_sensor_raw_converter #(
    parameter int CODE_BITS = 16,
    parameter int OUT_BITS  = 40
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [isrc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [isrc_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // Fields from bit 0 up: rp_code[15:0], l_code[15:0].
    input  wire logic [31:0]                         i_s_tdata,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // Fields from bit 0 up: rp_ohms_q8[OUT_BITS-1:0], inductance_ph[OUT_BITS-1:0].
    output logic [((2*OUT_BITS+7)/8)*8-1:0]          o_m_tdata,
    // Fields from bit 0 up: saturated.
    output logic                                     o_m_tuser
);

    localparam int EB    = (CODE_BITS < 16) ? CODE_BITS : 16;
    localparam int TDW   = ((2*OUT_BITS+7)/8)*8;
    localparam int NS    = OUT_BITS + 3;
    localparam int OHM   = isrc_pkg::OHM_BITS;
    localparam int RDW   = OHM + CODE_BITS + 1;
    localparam int RNMW  = 2*OHM + CODE_BITS + 8;
    localparam int RW    = (RNMW + 1 > RDW + OUT_BITS) ? RNMW + 1 : RDW + OUT_BITS;
    localparam int LNMW  = 2*CODE_BITS + isrc_pkg::LK_BITS;
    localparam int PSQW  = 2*isrc_pkg::PERIOD_BITS;
    localparam int LDW   = PSQW + isrc_pkg::CAP_BITS;
    localparam int LW    = (LNMW + 1 > LDW + OUT_BITS) ? LNMW + 1 : LDW + OUT_BITS;
    localparam logic [CODE_BITS-1:0] FULL = '1;
    localparam logic [OUT_BITS-1:0]  OMAX = '1;

    // Configuration registers.
    logic [OHM-1:0]                       r_rp_min;
    logic [OHM-1:0]                       r_rp_max;
    logic                                 r_high_q;
    logic [isrc_pkg::CAP_BITS-1:0]        r_cap;
    logic [isrc_pkg::PERIOD_BITS-1:0]     r_periods;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp_min  <= isrc_pkg::RST_RP_MIN;
            r_rp_max  <= isrc_pkg::RST_RP_MAX;
            r_high_q  <= isrc_pkg::RST_HIGH_Q;
            r_cap     <= isrc_pkg::RST_CAP;
            r_periods <= isrc_pkg::RST_PERIODS;
        end else if (i_cfg_valid) begin
            case (isrc_pkg::t_reg_idx'(i_cfg_index))
                isrc_pkg::REG_RP_MIN:  r_rp_min  <= i_cfg_data[OHM-1:0];
                isrc_pkg::REG_RP_MAX:  r_rp_max  <= i_cfg_data[OHM-1:0];
                isrc_pkg::REG_HIGH_Q:  r_high_q  <= i_cfg_data[0];
                isrc_pkg::REG_CAP:     r_cap     <= i_cfg_data[isrc_pkg::CAP_BITS-1:0];
                isrc_pkg::REG_PERIODS: r_periods <= i_cfg_data[isrc_pkg::PERIOD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Stage handshake: a stage advances when it is empty or its successor advances.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS:0]   adv;

    always_comb begin
        adv[NS] = i_m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = ~r_vld[k] | adv[k+1];
        end
    end

    assign n_vld      = {r_vld[NS-2:0], i_s_tvalid};
    assign o_s_tready = adv[0];
    assign o_m_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (adv[k]) r_vld[k] <= n_vld[k];
            end
        end
    end

    logic [CODE_BITS-1:0] s_rp;
    logic [CODE_BITS-1:0] s_lc;
    assign s_rp = CODE_BITS'(i_s_tdata[EB-1:0]);
    assign s_lc = CODE_BITS'(i_s_tdata[16+EB-1:16]);

    // Stage 0: first products.
    logic [OHM+CODE_BITS-1:0] r0_a1, r0_a2, r0_c;
    logic [2*OHM-1:0]         r0_b;
    logic [CODE_BITS-1:0]     r0_inv;
    logic [2*CODE_BITS-1:0]   r0_lsq;
    logic [PSQW-1:0]          r0_psq;
    logic                     r0_lz;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_a1  <= r_rp_max * (FULL - s_rp);
            r0_a2  <= r_rp_min * s_rp;
            r0_c   <= r_rp_min * FULL;
            r0_b   <= r_rp_max * r_rp_min;
            r0_inv <= FULL - s_rp;
            r0_lsq <= s_lc * s_lc;
            r0_psq <= r_periods * r_periods;
            r0_lz  <= (s_lc == '0);
        end
    end

    // Stage 1: numerators and divisors.
    logic [RDW-1:0]  r1_rd;
    logic [RNMW-1:0] r1_rn;
    logic [LNMW-1:0] r1_ln;
    logic [LDW-1:0]  r1_ld;
    logic            r1_lz;
    logic [2*OHM+CODE_BITS-1:0] n_rprod;

    assign n_rprod = r0_b * FULL;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_rd <= r_high_q ? RDW'(r0_inv) : RDW'(r0_a1) + RDW'(r0_a2);
            r1_rn <= r_high_q ? RNMW'({r0_c, 8'd0}) : {n_rprod, 8'd0};
            r1_ln <= r0_lsq * isrc_pkg::LK;
            r1_ld <= r0_psq * r_cap;
            r1_lz <= r0_lz;
        end
    end

    // Divider state; index 0 is loaded by the rounding stage, index OUT_BITS is final.
    logic [RW-1:0]       r_rrem [0:OUT_BITS];
    logic [RDW-1:0]      r_rd   [0:OUT_BITS];
    logic [OUT_BITS-1:0] r_rq   [0:OUT_BITS];
    logic                r_rsat [0:OUT_BITS];
    logic [LW-1:0]       r_lrem [0:OUT_BITS];
    logic [LDW-1:0]      r_ld   [0:OUT_BITS];
    logic [OUT_BITS-1:0] r_lq   [0:OUT_BITS];
    logic                r_lsat [0:OUT_BITS];
    logic                r_lz   [0:OUT_BITS];

    // Stage 2: add half the divisor for round-to-nearest and catch overflow up front,
    // which also guarantees the restoring steps below never lose a quotient bit.
    logic [RW-1:0] n_rnum;
    logic [LW-1:0] n_lnum;
    assign n_rnum = RW'(r1_rn) + RW'(r1_rd >> 1);
    assign n_lnum = LW'(r1_ln) + LW'(r1_ld >> 1);

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_rrem[0] <= n_rnum;
            r_rd[0]   <= r1_rd;
            r_rq[0]   <= '0;
            r_rsat[0] <= (r1_rd == '0) || (n_rnum >= (RW'(r1_rd) << OUT_BITS));
            r_lrem[0] <= n_lnum;
            r_ld[0]   <= r1_ld;
            r_lq[0]   <= '0;
            r_lsat[0] <= (r1_ld == '0) || (n_lnum >= (LW'(r1_ld) << OUT_BITS));
            r_lz[0]   <= r1_lz;
        end
    end

    for (genvar k = 0; k < OUT_BITS; k++) begin : g_div
        localparam int J = OUT_BITS - 1 - k;
        logic [RW-1:0] rt;
        logic [LW-1:0] lt;
        logic          rge, lge;
        assign rt  = RW'(r_rd[k]) << J;
        assign lt  = LW'(r_ld[k]) << J;
        assign rge = r_rrem[k] >= rt;
        assign lge = r_lrem[k] >= lt;

        always_ff @(posedge i_clk) begin
            if (adv[k+3]) begin
                r_rrem[k+1] <= rge ? r_rrem[k] - rt : r_rrem[k];
                r_rq[k+1]   <= r_rq[k] | (rge ? (OUT_BITS'(1) << J) : '0);
                r_rd[k+1]   <= r_rd[k];
                r_rsat[k+1] <= r_rsat[k];
                r_lrem[k+1] <= lge ? r_lrem[k] - lt : r_lrem[k];
                r_lq[k+1]   <= r_lq[k] | (lge ? (OUT_BITS'(1) << J) : '0);
                r_ld[k+1]   <= r_ld[k];
                r_lsat[k+1] <= r_lsat[k];
                r_lz[k+1]   <= r_lz[k];
            end
        end
    end

    logic [OUT_BITS-1:0] n_rres, n_lres;
    assign n_rres = r_rsat[OUT_BITS] ? OMAX : r_rq[OUT_BITS];
    assign n_lres = r_lz[OUT_BITS] ? '0 : (r_lsat[OUT_BITS] ? OMAX : r_lq[OUT_BITS]);

    assign o_m_tdata = TDW'({n_lres, n_rres});
    assign o_m_tuser = r_rsat[OUT_BITS] | (~r_lz[OUT_BITS] & r_lsat[OUT_BITS]);

    // Stage 2, when held, keeps its item.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && !adv[2]) |=> r_vld[2])
        else $error("pipeline stage dropped a stalled item");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld == '0) |-> o_s_tready)
        else $error("empty pipeline refuses input");

    a_rp_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && !r_rsat[OUT_BITS]) |-> (r_rrem[OUT_BITS] < RW'(r_rd[OUT_BITS])))
        else $error("Rp divider remainder not below divisor");

    a_l_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-1] && !r_lsat[OUT_BITS]) |-> (r_lrem[OUT_BITS] < LW'(r_ld[OUT_BITS])))
        else $error("L divider remainder not below divisor");

endmodule

`default_nettype wire

/* test/tb_inductive_sensor_raw_converter.sv */
// Testbench for the inductive sensor raw-code converter: Rp and L from raw code pairs.
// Predicts each result with exact integer arithmetic and checks it field by field.
// Depends on isrc_pkg and inductive_sensor_raw_converter.
`timescale 1ns / 1ps

module tb_inductive_sensor_raw_converter;

    localparam int OUT_BITS = 40;
    localparam int TD_BITS  = ((2*OUT_BITS+7)/8)*8;
    localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};
    localparam logic [15:0] FULL = 16'hFFFF;
    localparam int LATENCY = OUT_BITS + 3;

    typedef struct packed {
        logic [OUT_BITS-1:0] rp_q8;
        logic [OUT_BITS-1:0] l_ph;
        logic                sat;
    } t_conv_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [isrc_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [isrc_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [31:0] i_s_tdata = '0;           // rp_code[15:0], l_code[15:0]
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [TD_BITS-1:0] o_m_tdata;         // rp_ohms_q8, inductance_ph
    logic o_m_tuser;                       // saturated

    // Predictor copy of the registers.
    logic [16:0] rp_min_reg = isrc_pkg::RST_RP_MIN;
    logic [16:0] rp_max_reg = isrc_pkg::RST_RP_MAX;
    logic        high_q_reg = isrc_pkg::RST_HIGH_Q;
    logic [15:0] cap_reg    = isrc_pkg::RST_CAP;
    logic [12:0] periods_reg = isrc_pkg::RST_PERIODS;

    t_conv_result expected_results[$];
    int  mismatch_count = 0;
    bit  no_idle = 1'b0;

    inductive_sensor_raw_converter #(.CODE_BITS(16), .OUT_BITS(OUT_BITS)) dut (.*);

    always #1 i_clk = ~i_clk;

    // Rounded quotient of num by den, clipped to the output range.
    function automatic logic [OUT_BITS-1:0] round_div(input logic [127:0] num,
                                                     input logic [127:0] den,
                                                     inout logic sat);
        logic [127:0] q;
        if (den == 0) begin
            sat = 1'b1;
            return OUT_MAX;
        end
        q = (num + (den >> 1)) / den;
        if (q > OUT_MAX) begin
            sat = 1'b1;
            return OUT_MAX;
        end
        return q[OUT_BITS-1:0];
    endfunction

    function automatic t_conv_result convert_codes(input logic [15:0] rp, input logic [15:0] lc);
        t_conv_result r;
        logic s;
        logic [127:0] den;
        s = 1'b0;
        if (high_q_reg) begin
            r.rp_q8 = round_div(128'(rp_min_reg) * FULL * 256, 128'(FULL - rp), s);
        end else begin
            den = 128'(rp_max_reg) * (FULL - rp) + 128'(rp_min_reg) * rp;
            r.rp_q8 = round_div(128'(rp_max_reg) * rp_min_reg * FULL * 256, den, s);
        end
        r.l_ph = '0;
        if (lc != 0)
            r.l_ph = round_div(128'(lc) * lc * isrc_pkg::LK,
                               128'(periods_reg) * periods_reg * cap_reg, s);
        r.sat = s;
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 24);
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                   input logic [OUT_BITS-1:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // The valid stays high after an item is taken; the next call either drives a new
    // item or first drops the valid while it idles.
    task automatic send_codes(input logic [15:0] rp, input logic [15:0] lc);
        while (idle_now()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        expected_results.push_back(convert_codes(rp, lc));
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {lc, rp};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input isrc_pkg::t_reg_idx idx, input logic [16:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            isrc_pkg::REG_RP_MIN:  rp_min_reg  = value;
            isrc_pkg::REG_RP_MAX:  rp_max_reg  = value;
            isrc_pkg::REG_HIGH_Q:  high_q_reg  = value[0];
            isrc_pkg::REG_CAP:     cap_reg     = value[15:0];
            isrc_pkg::REG_PERIODS: periods_reg = value[12:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_all(input logic [16:0] mn, input logic [16:0] mx, input logic hq,
                           input logic [15:0] cap, input logic [12:0] per);
        drain();
        write_reg(isrc_pkg::REG_RP_MIN, mn);
        write_reg(isrc_pkg::REG_RP_MAX, mx);
        write_reg(isrc_pkg::REG_HIGH_Q, 17'(hq));
        write_reg(isrc_pkg::REG_CAP, 17'(cap));
        write_reg(isrc_pkg::REG_PERIODS, 17'(per));
    endtask

    // Result checker with random backpressure.
    always @(posedge i_clk) begin
        t_conv_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[OUT_BITS-1:0], '0);
            end else begin
                want = expected_results.pop_front();
                if (o_m_tdata[OUT_BITS-1:0] !== want.rp_q8)
                    report_mismatch("rp_ohms_q8", o_m_tdata[OUT_BITS-1:0], want.rp_q8);
                if (o_m_tdata[2*OUT_BITS-1:OUT_BITS] !== want.l_ph)
                    report_mismatch("inductance_ph", o_m_tdata[2*OUT_BITS-1:OUT_BITS],
                                    want.l_ph);
                if (o_m_tuser !== want.sat)
                    report_mismatch("saturated", 40'(o_m_tuser), 40'(want.sat));
            end
        end
        i_m_tready <= i_rst_n && !idle_now();
    end

    task automatic test_directed_edges();
        logic [15:0] codes[6] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};
        foreach (codes[i]) send_codes(codes[i], codes[5 - i]);
    endtask

    task automatic test_high_q();
        set_all(17'd750, 17'd96000, 1'b1, 16'd100, 13'd6144);
        send_codes(16'hFFFF, 16'h1234);   // zero divisor
        send_codes(16'h0000, 16'hFFFF);
        send_codes(16'hFFFE, 16'h0000);
        set_all(17'h1FFFF, 17'd750, 1'b1, 16'd1, 13'd192);
        send_codes(16'hFFFE, 16'hFFFF);   // overflow on both sides
        send_codes(16'h5555, 16'hAAAA);
    endtask

    task automatic test_odd_registers();
        // Zero range ends give a zero divisor or a zero Rp; zero period and cap give zero L divisor.
        set_all(17'd0, 17'd0, 1'b0, 16'd0, 13'd0);
        send_codes(16'h1111, 16'h0001);
        send_codes(16'h1111, 16'h0000);
        set_all(17'd0, 17'd96000, 1'b0, 16'hFFFF, 13'h1FFF);
        send_codes(16'h0000, 16'hFFFF);
        send_codes(16'hFFFF, 16'h0001);
        drain();
        write_reg(isrc_pkg::t_reg_idx'(3'd7), 17'h1FFFF);   // out of list, ignored
        send_codes(16'h4000, 16'h4000);
    endtask

    task automatic test_random_items(input int count);
        int phase;
        for (int n = 0; n < count; n++) begin
            if (n % 250 == 0) begin
                phase = n / 250;
                no_idle = (phase == 3);
                set_all(17'($urandom_range(phase[0] ? 17'h1FFFF : 96000, 750)),
                        17'($urandom_range(phase[1] ? 17'h1FFFF : 96000, 750)),
                        1'($urandom_range(1)), 16'($urandom_range(65535, 1)),
                        13'($urandom_range(n % 500 == 0 ? 8191 : 6144, 192)));
            end
            send_codes(16'($urandom), ($urandom_range(15) == 0) ? 16'h0 : 16'($urandom));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_high_q();
        test_odd_registers();
        set_all(isrc_pkg::RST_RP_MIN, isrc_pkg::RST_RP_MAX, isrc_pkg::RST_HIGH_Q,
                isrc_pkg::RST_CAP, isrc_pkg::RST_PERIODS);
        test_random_items(1750);
        drain();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
